### rtl/hmpf_pkg.sv
// Package with beat types, register codes, pipeline record and constant functions.
`timescale 1ns / 1ps
`default_nettype none
package hmpf_pkg;

    localparam int unsigned Q24_ONE    = 32'd16777216;
    localparam logic [23:0] HALF_LOG2E = 24'd12102203;
    localparam int unsigned DIV_STAGES = 14;
    localparam int unsigned DIV_BITS   = 4;
    localparam int unsigned LOG_STEPS  = 24;
    localparam int unsigned POW_STEPS  = 24;

    typedef enum logic [1:0] {
        CFG_PERM_REF       = 2'd0,
        CFG_SOLID_FRACTION = 2'd1,
        CFG_EXP_COEFF      = 2'd2,
        CFG_POWER_EXP      = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BELOW = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        K_NORMAL = 2'd0,
        K_BELOW  = 2'd1,
        K_EQUAL  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [31:0]        rel_volume;
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
        logic signed [31:0] grad_z;
    } t_in_beat;

    typedef struct packed {
        logic [31:0]        perm_now;
        logic signed [31:0] flux_x;
        logic signed [31:0] flux_y;
        logic signed [31:0] flux_z;
        logic [1:0]         status;
    } t_out_beat;

    typedef struct packed {
        logic [31:0] perm_ref;
        logic [23:0] solid_fraction;
        logic [31:0] exp_coeff;
        logic [31:0] power_exp;
    } t_cfg;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic signed [31:0] gz;
        logic [39:0]        jj;
        logic [39:0]        u;
        logic [55:0]        pa;
        logic [55:0]        pb;
        logic signed [48:0] eexp;
        logic [25:0]        rem;
        logic [55:0]        quo;
        logic [63:0]        nrm;
        logic [5:0]         lz;
        logic [30:0]        m;
        logic [23:0]        frac;
        logic [38:0]        pm;
        logic               lneg;
        logic signed [50:0] e;
        logic [30:0]        acc;
        logic [62:0]        pp;
        logic [31:0]        k0;
        logic               sat;
        logic [63:0]        qx;
        logic [63:0]        qy;
        logic [63:0]        qz;
    } t_work;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        logic [63:0] xx;
        res = '0;
        b   = 64'h4000_0000_0000_0000;
        xx  = x;
        for (int i = 0; i < 32; i++) begin
            if (xx >= res + b) begin
                xx  = xx - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Returns 2^(2^-(k+1)) in Q1.30, built by a chain of repeated square roots of 2.0.
    function automatic logic [30:0] pow2_root(input int k);
        logic [63:0] c;
        c = 64'h8000_0000;
        for (int i = 0; i <= k; i++) begin
            c = isqrt64(c << 30);
        end
        return c[30:0];
    endfunction

endpackage
`default_nettype wire

### rtl/hmpf_front.sv
// Input stages: case decode, division setup and the exponential strain term.
`timescale 1ns / 1ps
`default_nettype none
module hmpf_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  hmpf_pkg::t_in_beat  i_beat,
    input  hmpf_pkg::t_cfg      i_cfg,
    output logic                o_valid,
    output hmpf_pkg::t_work     o_work
);
    import hmpf_pkg::*;

    logic [3:0]  r_valid;
    t_work       r_w1, r_w2, r_w3, r_w4;
    t_work       n_w1, n_w2, n_w3, n_w4;
    logic [31:0] phi;
    logic        alpha_nz;
    logic [63:0] jprod;
    logic [39:0] ad;
    logic [63:0] uprod;
    logic        dneg;
    logic [56:0] lo;
    logic [48:0] t;

    assign phi      = {8'b0, i_cfg.solid_fraction};
    assign alpha_nz = (i_cfg.power_exp != 32'd0);
    assign jprod    = 64'(i_beat.rel_volume) * 64'(i_beat.rel_volume);

    always_comb begin
        n_w1      = '0;
        n_w1.gx   = i_beat.grad_x;
        n_w1.gy   = i_beat.grad_y;
        n_w1.gz   = i_beat.grad_z;
        n_w1.jj   = jprod[63:24];
        n_w1.quo  = {i_beat.rel_volume - phi, 24'b0};
        n_w1.kind = K_NORMAL;
        if (i_beat.rel_volume < phi && alpha_nz) begin
            n_w1.kind = K_BELOW;
        end else if (i_beat.rel_volume == phi && alpha_nz) begin
            n_w1.kind = K_EQUAL;
        end
    end

    assign ad    = (r_w1.jj < 40'(Q24_ONE)) ? (40'(Q24_ONE) - r_w1.jj)
                                              : (r_w1.jj - 40'(Q24_ONE));
    assign uprod = 64'(ad) * 64'(HALF_LOG2E);

    always_comb begin
        n_w2   = r_w1;
        n_w2.u = uprod[63:24];
    end

    always_comb begin
        n_w3    = r_w2;
        n_w3.pa = 56'(i_cfg.exp_coeff[31:16]) * 56'(r_w2.u);
        n_w3.pb = 56'(i_cfg.exp_coeff[15:0]) * 56'(r_w2.u);
    end

    assign dneg = (r_w3.jj < 40'(Q24_ONE));
    assign lo   = 57'({r_w3.pa[7:0], 16'b0}) + 57'(r_w3.pb);
    assign t    = 49'(r_w3.pa[55:8]) + 49'(lo[56:24]);

    always_comb begin
        n_w4      = r_w3;
        n_w4.eexp = dneg ? -$signed(t) : $signed(t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w1 <= n_w1;
            r_w2 <= n_w2;
            r_w3 <= n_w3;
            r_w4 <= n_w4;
        end
    end

    assign o_valid = r_valid[3];
    assign o_work  = r_w4;

endmodule
`default_nettype wire

### rtl/hmpf_div_stage.sv
// One divider stage: four restoring quotient bits of the volume ratio.
`timescale 1ns / 1ps
`default_nettype none
module hmpf_div_stage (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  wire [24:0]       i_den,
    input  wire              i_valid,
    input  hmpf_pkg::t_work  i_work,
    output logic             o_valid,
    output hmpf_pkg::t_work  o_work
);
    import hmpf_pkg::*;

    logic  r_valid;
    t_work r_work;
    t_work n_work;

    always_comb begin
        n_work = i_work;
        for (int i = 0; i < DIV_BITS; i++) begin
            n_work.rem = {n_work.rem[24:0], n_work.quo[55]};
            n_work.quo = {n_work.quo[54:0], 1'b0};
            if (n_work.rem >= 26'(i_den)) begin
                n_work.rem    = n_work.rem - 26'(i_den);
                n_work.quo[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule
`default_nettype wire

### rtl/hmpf_log_stage.sv
// One log2 stage: squares the mantissa and produces one fraction bit.
`timescale 1ns / 1ps
`default_nettype none
module hmpf_log_stage (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  wire              i_valid,
    input  hmpf_pkg::t_work  i_work,
    output logic             o_valid,
    output hmpf_pkg::t_work  o_work
);
    import hmpf_pkg::*;

    logic        r_valid;
    t_work       r_work;
    t_work       n_work;
    logic [61:0] sq_full;
    logic [31:0] sq;

    assign sq_full = 62'(i_work.m) * 62'(i_work.m);
    assign sq      = sq_full[61:30];

    always_comb begin
        n_work      = i_work;
        n_work.frac = {i_work.frac[22:0], sq[31]};
        n_work.m    = sq[31] ? sq[31:1] : sq[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule
`default_nettype wire

### rtl/hmpf_pow2_stage.sv
// One 2^f stage: multiplies in the root factor for one fraction bit.
`timescale 1ns / 1ps
`default_nettype none
module hmpf_pow2_stage #(
    parameter int STEP = 0
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  wire              i_valid,
    input  hmpf_pkg::t_work  i_work,
    output logic             o_valid,
    output hmpf_pkg::t_work  o_work
);
    import hmpf_pkg::*;

    localparam logic [30:0] ROOT = pow2_root(STEP);

    logic        r_valid;
    t_work       r_work;
    t_work       n_work;
    logic [61:0] prod;

    assign prod = 62'(i_work.acc) * 62'(ROOT);

    always_comb begin
        n_work = i_work;
        if (i_work.e[23 - STEP]) begin
            n_work.acc = prod[60:30];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule
`default_nettype wire

### rtl/hmpf_back.sv
// Output stages: permeability scaling, saturation, flux products and clamping.
`timescale 1ns / 1ps
`default_nettype none
module hmpf_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire [31:0]          i_perm_ref,
    input  wire                 i_valid,
    input  hmpf_pkg::t_work     i_work,
    output logic                o_valid,
    output hmpf_pkg::t_out_beat o_beat
);
    import hmpf_pkg::*;

    logic [3:0]         r_valid;
    t_work              r_w1, r_w2, r_w3;
    t_work              n_w1, n_w2, n_w3;
    t_out_beat          r_out;
    t_out_beat          n_out;
    logic signed [26:0] n_exp;
    logic signed [26:0] sdiff;
    logic [63:0]        q;
    logic [32:0]        cx, cy, cz;

    function automatic logic [32:0] clamp_flux(input logic [63:0] prod, input logic gneg);
        logic [47:0] qq;
        logic [32:0] res;
        qq = prod[63:16];
        if (gneg) begin
            if (qq > 48'h7FFF_FFFF) begin
                res = {1'b1, 32'h7FFF_FFFF};
            end else begin
                res = {1'b0, qq[31:0]};
            end
        end else begin
            if (qq > 48'h8000_0000) begin
                res = {1'b1, 32'h8000_0000};
            end else begin
                res = {1'b0, 32'(-qq[31:0])};
            end
        end
        return res;
    endfunction

    always_comb begin
        n_w1    = i_work;
        n_w1.pp = 63'(i_perm_ref) * 63'(i_work.acc);
    end

    assign n_exp = r_w1.e[50:24];
    assign sdiff = 27'sd30 - n_exp;

    always_comb begin
        n_w2     = r_w1;
        n_w2.k0  = '0;
        n_w2.sat = 1'b0;
        q        = '0;
        if (r_w1.kind == K_NORMAL && i_perm_ref != 32'd0) begin
            if (n_exp >= 27'sd32) begin
                n_w2.k0  = 32'hFFFF_FFFF;
                n_w2.sat = 1'b1;
            end else if (n_exp >= -27'sd64) begin
                if (n_exp <= 27'sd30) begin
                    q = 64'(r_w1.pp) >> sdiff[6:0];
                end else begin
                    q = {r_w1.pp, 1'b0};
                end
                if (q > 64'hFFFF_FFFF) begin
                    n_w2.k0  = 32'hFFFF_FFFF;
                    n_w2.sat = 1'b1;
                end else begin
                    n_w2.k0 = q[31:0];
                end
            end
        end
    end

    always_comb begin
        n_w3    = r_w2;
        n_w3.qx = 64'(r_w2.k0) * 64'($unsigned(r_w2.gx[31] ? -r_w2.gx : r_w2.gx));
        n_w3.qy = 64'(r_w2.k0) * 64'($unsigned(r_w2.gy[31] ? -r_w2.gy : r_w2.gy));
        n_w3.qz = 64'(r_w2.k0) * 64'($unsigned(r_w2.gz[31] ? -r_w2.gz : r_w2.gz));
    end

    assign cx = clamp_flux(r_w3.qx, r_w3.gx[31]);
    assign cy = clamp_flux(r_w3.qy, r_w3.gy[31]);
    assign cz = clamp_flux(r_w3.qz, r_w3.gz[31]);

    always_comb begin
        n_out.perm_now = r_w3.k0;
        n_out.flux_x   = $signed(cx[31:0]);
        n_out.flux_y   = $signed(cy[31:0]);
        n_out.flux_z   = $signed(cz[31:0]);
        if (r_w3.kind == K_BELOW) begin
            n_out.status = ST_BELOW;
        end else if (r_w3.sat || cx[32] || cy[32] || cz[32]) begin
            n_out.status = ST_SAT;
        end else begin
            n_out.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w1  <= n_w1;
            r_w2  <= n_w2;
            r_w3  <= n_w3;
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid[3];
    assign o_beat  = r_out;

endmodule
`default_nettype wire

### rtl/holmes_mow_permeability_flux.sv
// Top level of the strain-dependent permeability and fluid flux pipeline.
// The block accepts one material point per clock cycle while the output side does not stall
// and returns one result beat per input beat, in order. The pipeline is a chain of stages:
// 4 input stages, 14 divider stages of 4 quotient bits each, 3 normalization stages, 24 log2
// squaring stages, 2 exponent stages, 24 stages of the 2^f product and 4 output stages. A
// stall on the output freezes the whole pipeline, and the output register holds the waiting
// beat and o_in_ready stays low until that beat is taken. Configuration registers are
// written through a plain write port and must only change while no beat is in flight.
`timescale 1ns / 1ps
`default_nettype none
module holmes_mow_permeability_flux (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  hmpf_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output hmpf_pkg::t_out_beat o_out_beat,
    input  wire                 i_cfg_we,
    input  wire [1:0]           i_cfg_idx,
    input  wire [31:0]          i_cfg_data
);
    import hmpf_pkg::*;

    t_cfg        r_cfg;
    logic        stage_en;
    logic [24:0] den;

    logic        v_div [DIV_STAGES+1];
    t_work       w_div [DIV_STAGES+1];
    logic        v_log [LOG_STEPS+1];
    t_work       w_log [LOG_STEPS+1];
    logic        v_pow [POW_STEPS+1];
    t_work       w_pow [POW_STEPS+1];

    logic [2:0]  r_nv;
    t_work       r_n1, r_n2, r_n3;
    t_work       n_n1, n_n2, n_n3;
    logic [1:0]  r_ev;
    t_work       r_e1, r_e2;
    t_work       n_e1, n_e2;

    logic signed [6:0]  lint;
    logic signed [30:0] lval;
    logic [30:0]        lmag;
    logic [62:0]        pmprod;
    logic signed [39:0] epow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.perm_ref       <= 32'd65536;
            r_cfg.solid_fraction <= '0;
            r_cfg.exp_coeff      <= '0;
            r_cfg.power_exp      <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PERM_REF:       r_cfg.perm_ref       <= i_cfg_data;
                CFG_SOLID_FRACTION: r_cfg.solid_fraction <= i_cfg_data[23:0];
                CFG_EXP_COEFF:      r_cfg.exp_coeff      <= i_cfg_data;
                CFG_POWER_EXP:      r_cfg.power_exp      <= i_cfg_data;
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    assign stage_en   = !o_out_valid || i_out_ready;
    assign o_in_ready = stage_en;
    assign den        = 25'(Q24_ONE) - 25'(r_cfg.solid_fraction);

    hmpf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (stage_en),
        .i_valid (i_in_valid),
        .i_beat  (i_in_beat),
        .i_cfg   (r_cfg),
        .o_valid (v_div[0]),
        .o_work  (w_div[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        hmpf_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (stage_en),
            .i_den   (den),
            .i_valid (v_div[g]),
            .i_work  (w_div[g]),
            .o_valid (v_div[g+1]),
            .o_work  (w_div[g+1])
        );
    end

    always_comb begin
        n_n1     = w_div[DIV_STAGES];
        n_n1.nrm = {8'b0, w_div[DIV_STAGES].quo};
        n_n1.lz  = '0;
        if (n_n1.nrm[63:32] == '0) begin
            n_n1.nrm = n_n1.nrm << 32;
            n_n1.lz  = n_n1.lz + 6'd32;
        end
        if (n_n1.nrm[63:48] == '0) begin
            n_n1.nrm = n_n1.nrm << 16;
            n_n1.lz  = n_n1.lz + 6'd16;
        end
    end

    always_comb begin
        n_n2 = r_n1;
        if (n_n2.nrm[63:56] == '0) begin
            n_n2.nrm = n_n2.nrm << 8;
            n_n2.lz  = n_n2.lz + 6'd8;
        end
        if (n_n2.nrm[63:60] == '0) begin
            n_n2.nrm = n_n2.nrm << 4;
            n_n2.lz  = n_n2.lz + 6'd4;
        end
    end

    always_comb begin
        n_n3 = r_n2;
        if (n_n3.nrm[63:62] == '0) begin
            n_n3.nrm = n_n3.nrm << 2;
            n_n3.lz  = n_n3.lz + 6'd2;
        end
        if (n_n3.nrm[63] == 1'b0) begin
            n_n3.nrm = n_n3.nrm << 1;
            n_n3.lz  = n_n3.lz + 6'd1;
        end
        n_n3.m    = n_n3.nrm[63:33];
        n_n3.frac = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv <= '0;
        end else if (stage_en) begin
            r_nv <= {r_nv[1:0], v_div[DIV_STAGES]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en) begin
            r_n1 <= n_n1;
            r_n2 <= n_n2;
            r_n3 <= n_n3;
        end
    end

    assign v_log[0] = r_nv[2];
    assign w_log[0] = r_n3;

    for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
        hmpf_log_stage u_log (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (stage_en),
            .i_valid (v_log[g]),
            .i_work  (w_log[g]),
            .o_valid (v_log[g+1]),
            .o_work  (w_log[g+1])
        );
    end

    // The integer part of log2 is the leading one position less 24, and the
    // fraction bits complete it as one two's complement word.
    assign lint   = 7'sd39 - $signed({1'b0, w_log[LOG_STEPS].lz});
    assign lval   = {lint, w_log[LOG_STEPS].frac};
    assign lmag   = lval[30] ? 31'(-lval) : 31'(lval);
    assign pmprod = 63'(r_cfg.power_exp) * 63'(lmag);

    always_comb begin
        n_e1      = w_log[LOG_STEPS];
        n_e1.pm   = pmprod[62:24];
        n_e1.lneg = lval[30];
    end

    assign epow = r_e1.lneg ? -$signed({1'b0, r_e1.pm}) : $signed({1'b0, r_e1.pm});

    always_comb begin
        n_e2     = r_e1;
        n_e2.e   = 51'(epow) + 51'(r_e1.eexp);
        n_e2.acc = 31'h4000_0000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= '0;
        end else if (stage_en) begin
            r_ev <= {r_ev[0], v_log[LOG_STEPS]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en) begin
            r_e1 <= n_e1;
            r_e2 <= n_e2;
        end
    end

    assign v_pow[0] = r_ev[1];
    assign w_pow[0] = r_e2;

    for (genvar g = 0; g < POW_STEPS; g++) begin : g_pow
        hmpf_pow2_stage #(
            .STEP (g)
        ) u_pow (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (stage_en),
            .i_valid (v_pow[g]),
            .i_work  (w_pow[g]),
            .o_valid (v_pow[g+1]),
            .o_work  (w_pow[g+1])
        );
    end

    hmpf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (stage_en),
        .i_perm_ref (r_cfg.perm_ref),
        .i_valid    (v_pow[POW_STEPS]),
        .i_work     (w_pow[POW_STEPS]),
        .o_valid    (o_out_valid),
        .o_beat     (o_out_beat)
    );

endmodule
`default_nettype wire
